// ----- sv/vcsg_pkg.sv -----
// ----------------------------------------------------------------------------
// vcsg_pkg - shared types and constants of the command safety governor
// Field widths, register indexes, codes, limits and divider sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vcsg_pkg;

   // field widths
   localparam int VEL_W      = 16;
   localparam int DIST_W     = 17;
   localparam int MASK_W     = 6;
   localparam int MAXSPD_W   = 15;
   localparam int GPS_W      = 16;
   localparam int FLAG_W     = 7;
   localparam int LEVEL_W    = 7;
   localparam int FUNC_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // serial divider: numerator below den * 2^16, so 16 steps give the quotient
   localparam int DIV_NUM_W  = 32;
   localparam int DIV_DEN_W  = 17;
   localparam int DIV_QUO_W  = 16;
   localparam int DIV_STEPS  = 16;
   localparam int DIV_CNT_W  = 4;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   // operation codes of the input word
   typedef enum logic [FUNC_W-1:0] {
      FUNC_VEHICLE   = 2'd0,
      FUNC_IMPLEMENT = 2'd1,
      FUNC_ESTOP     = 2'd2
   } func_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE_MASK      = 3'd0,
      CSR_WARNING_DISTANCE = 3'd1,
      CSR_BRAKE_DISTANCE   = 3'd2,
      CSR_MAX_SPEED        = 3'd3,
      CSR_GPS_THRESHOLD    = 3'd4
   } csr_index_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_APPLY
   } state_type;

   // enable mask bits
   localparam int EN_COLLISION = 0;
   localparam int EN_LANE      = 1;
   localparam int EN_CRUISE    = 2;
   localparam int EN_TREE      = 3;
   localparam int EN_GPS       = 4;
   localparam int EN_LIMIT     = 5;

   // status flag bits
   localparam int FL_WARNING = 0;
   localparam int FL_BRAKING = 1;
   localparam int FL_LANE    = 2;
   localparam int FL_CRUISE  = 3;
   localparam int FL_TREE    = 4;
   localparam int FL_GPS     = 5;
   localparam int FL_LIMIT   = 6;

   // register reset values
   localparam logic [MASK_W-1:0]   RST_ENABLE_MASK = 6'd63;
   localparam logic [DIST_W-1:0]   RST_WARNING     = 17'd10000;
   localparam logic [DIST_W-1:0]   RST_BRAKE       = 17'd3000;
   localparam logic [MAXSPD_W-1:0] RST_MAX_SPEED   = 15'd5000;
   localparam logic [GPS_W-1:0]    RST_GPS_THRESH  = 16'd100;

   // stage limits
   localparam logic signed [VEL_W-1:0] TREE_SPEED  = 16'sd2000;
   localparam logic [DIST_W-1:0]       FOLLOW_DIST = 17'd20000;
   localparam logic [DIST_W-1:0]       LANE_THRESH = 17'd500;
   localparam logic [DIST_W-1:0]       LANE_CLAMP  = 17'd1010;
   localparam logic [6:0]              LANE_MAX_CORR = 7'd100;
   localparam logic [12:0]             RECIP_TEN   = 13'd6554;
   localparam logic signed [VEL_W:0]   STEER_MAX   = 17'sd32767;
   localparam logic signed [VEL_W:0]   STEER_MIN   = -17'sd32767;

   // safety level penalties
   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;
   localparam logic [LEVEL_W-1:0] PEN_WARN   = 7'd30;
   localparam logic [LEVEL_W-1:0] PEN_BRAKE  = 7'd50;
   localparam logic [LEVEL_W-1:0] PEN_GPS    = 7'd20;
   localparam logic [LEVEL_W-1:0] PEN_TREE   = 7'd10;

endpackage

// ----- sv/vcsg_div.sv -----
// ----------------------------------------------------------------------------
// vcsg_div - restoring divider, one quotient bit per cycle
// Takes the numerator and divisor on start; done marks the last step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vcsg_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [vcsg_pkg::DIV_NUM_W-1:0]  numer,
   input  logic [vcsg_pkg::DIV_DEN_W-1:0]  denom,
   output logic                            done,
   output logic [vcsg_pkg::DIV_QUO_W-1:0]  quotient
);
   import vcsg_pkg::*;

   logic                  busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [DIV_DEN_W-1:0]  rem_ff, rem_in;
   logic [DIV_QUO_W-1:0]  num_ff, num_in;
   logic [DIV_DEN_W-1:0]  den_ff, den_in;
   logic [DIV_DEN_W:0]    shifted;
   logic [DIV_DEN_W:0]    trial;
   logic                  fits;

   assign shifted = {rem_ff, num_ff[DIV_QUO_W-1]};
   assign trial   = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = {1'b0, numer[DIV_NUM_W-1:DIV_QUO_W]};
         num_in   = numer[DIV_QUO_W-1:0];
         den_in   = denom;
      end else if (busy_ff) begin
         // shift in the next numerator bit, the quotient bit enters at the bottom
         rem_in   = fits ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
         num_in   = {num_ff[DIV_QUO_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign done     = busy_ff && (count_ff == DIV_LAST);
   assign quotient = num_ff;

endmodule

// ----- sv/vehicle_command_safety_governor.sv -----
// ----------------------------------------------------------------------------
// vehicle_command_safety_governor - drive command safety filter
// One word is handled at a time: req_stall stays high from the accepted
// word until its result is registered. The 16-step serial divider scales
// velocity in the collision-warning zone; a stalled result holds the
// block in its final step. Reset is synchronous: status flags clear and
// the configuration registers take their default values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vehicle_command_safety_governor (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_wr_en,
   input  logic [vcsg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [vcsg_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [vcsg_pkg::FUNC_W-1:0]           req_func,
   input  logic signed [vcsg_pkg::VEL_W-1:0]     req_linear_velocity_in,
   input  logic signed [vcsg_pkg::VEL_W-1:0]     req_angular_velocity_in,
   input  logic signed [vcsg_pkg::VEL_W-1:0]     req_steering_in,
   input  logic                                  req_estop_in,
   input  logic                                  req_activate_in,
   input  logic [vcsg_pkg::DIST_W-1:0]           req_obstacle_distance,
   input  logic signed [vcsg_pkg::VEL_W-1:0]     req_lane_offset,
   input  logic [vcsg_pkg::GPS_W-1:0]            req_gps_accuracy,
   input  logic                                  req_trees_seen,
   input  logic                                  req_lane_seen,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [vcsg_pkg::VEL_W-1:0]     rsp_linear_velocity_out,
   output logic signed [vcsg_pkg::VEL_W-1:0]     rsp_angular_velocity_out,
   output logic signed [vcsg_pkg::VEL_W-1:0]     rsp_steering_out,
   output logic                                  rsp_vehicle_estop_out,
   output logic                                  rsp_implement_activate_out,
   output logic                                  rsp_implement_estop_out,
   output logic [vcsg_pkg::FLAG_W-1:0]           rsp_flag_bits,
   output logic [vcsg_pkg::LEVEL_W-1:0]          rsp_safety_score
);
   import vcsg_pkg::*;

   // configuration registers
   logic [MASK_W-1:0]    enable_ff;
   logic [DIST_W-1:0]    warn_ff;
   logic [DIST_W-1:0]    brake_ff;
   logic [MAXSPD_W-1:0]  max_speed_ff;
   logic [GPS_W-1:0]     gps_thresh_ff;

   // sequencer and status
   state_type            state_ff, state_in;
   logic [FLAG_W-1:0]    flags_ff, flags_in;
   logic                 last_trees_ff, last_trees_in;

   // captured request word
   logic [FUNC_W-1:0]        func_ff;
   logic signed [VEL_W-1:0]  lin_ff, ang_ff, steer_ff, offset_ff;
   logic                     estop_ff, activate_ff, trees_ff, lane_ff;
   logic [DIST_W-1:0]        dist_ff;
   logic [GPS_W-1:0]         gps_acc_ff;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [VEL_W-1:0]  rsp_lin_ff, rsp_ang_ff, rsp_steer_ff;
   logic                     rsp_vest_ff, rsp_iact_ff, rsp_iest_ff;
   logic [FLAG_W-1:0]        rsp_flags_ff;
   logic [LEVEL_W-1:0]       rsp_level_ff;

   // sequencer outputs
   logic                     req_take;
   logic                     div_start;
   logic                     apply_fire;

   // divider operands and result
   logic [VEL_W-1:0]         lin_mag;
   logic [DIST_W-1:0]        zone_pos;
   logic [DIST_W-1:0]        zone_len;
   logic [VEL_W+DIST_W-1:0]  scale_prod;
   logic                     div_done;
   logic [DIV_QUO_W-1:0]     div_quo;
   logic signed [VEL_W-1:0]  lin_scaled;

   // lane correction
   logic [DIST_W-1:0]        off_ext;
   logic [DIST_W-1:0]        off_mag;
   logic [22:0]              tenth_prod;
   logic [6:0]               corr_mag;
   logic signed [7:0]        corr;
   logic signed [VEL_W:0]    steer_sum;
   logic signed [VEL_W-1:0]  steer_corr;

   // stage outputs
   logic signed [VEL_W-1:0]  lin_v, ang_v, steer_v;
   logic                     vest_v, iact_v, iest_v;
   logic [LEVEL_W-1:0]       penalty;
   logic [LEVEL_W-1:0]       level_v;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= RST_ENABLE_MASK;
         warn_ff       <= RST_WARNING;
         brake_ff      <= RST_BRAKE;
         max_speed_ff  <= RST_MAX_SPEED;
         gps_thresh_ff <= RST_GPS_THRESH;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLE_MASK:      enable_ff     <= csr_wr_data[MASK_W-1:0];
            CSR_WARNING_DISTANCE: warn_ff       <= csr_wr_data[DIST_W-1:0];
            CSR_BRAKE_DISTANCE:   brake_ff      <= csr_wr_data[DIST_W-1:0];
            CSR_MAX_SPEED:        max_speed_ff  <= csr_wr_data[MAXSPD_W-1:0];
            CSR_GPS_THRESHOLD:    gps_thresh_ff <= csr_wr_data[GPS_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_APPLY;
         ST_APPLY: if (!(rsp_valid_ff && rsp_stall)) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      div_start  = 1'b0;
      apply_fire = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall  = 1'b0;
         ST_LOAD:  div_start  = 1'b1;
         ST_DIV:   ;
         ST_APPLY: apply_fire = !(rsp_valid_ff && rsp_stall);
         default:  ;
      endcase
   end

   assign req_take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         flags_ff      <= '0;
         last_trees_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flags_ff      <= flags_in;
         last_trees_ff <= last_trees_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // hold the request word for the whole computation
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff     <= req_func;
         lin_ff      <= req_linear_velocity_in;
         ang_ff      <= req_angular_velocity_in;
         steer_ff    <= req_steering_in;
         estop_ff    <= req_estop_in;
         activate_ff <= req_activate_in;
         dist_ff     <= req_obstacle_distance;
         offset_ff   <= req_lane_offset;
         gps_acc_ff  <= req_gps_accuracy;
         trees_ff    <= req_trees_seen;
         lane_ff     <= req_lane_seen;
      end
   end

   // -------------------------------------------------------- zone scaling
   // |lin| * (d - brake) / (warn - brake); only used inside the warning zone,
   // where the product stays below 2^32 and the quotient below |lin|
   assign lin_mag    = lin_ff[VEL_W-1] ? (VEL_W'(0) - lin_ff) : lin_ff;
   assign zone_pos   = dist_ff - brake_ff;
   assign zone_len   = warn_ff - brake_ff;
   assign scale_prod = lin_mag * zone_pos;

   vcsg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (scale_prod[DIV_NUM_W-1:0]),
      .denom    (zone_len),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign lin_scaled = lin_ff[VEL_W-1] ? $signed(VEL_W'(0) - div_quo) : $signed(div_quo);

   // -------------------------------------------------------- lane keeping
   assign off_ext    = {offset_ff[VEL_W-1], offset_ff};
   assign off_mag    = offset_ff[VEL_W-1] ? (DIST_W'(0) - off_ext) : off_ext;
   // divide by ten through the reciprocal; exact for magnitudes below the clamp
   assign tenth_prod = off_mag[9:0] * RECIP_TEN;
   assign corr_mag   = (off_mag >= LANE_CLAMP) ? LANE_MAX_CORR : tenth_prod[22:16];
   assign corr       = offset_ff[VEL_W-1] ? $signed({1'b0, corr_mag})
                                          : $signed(8'd0 - {1'b0, corr_mag});
   assign steer_sum  = {steer_ff[VEL_W-1], steer_ff} + {{9{corr[7]}}, corr};

   always_comb begin
      if (steer_sum > STEER_MAX) begin
         steer_corr = STEER_MAX[VEL_W-1:0];
      end else if (steer_sum < STEER_MIN) begin
         steer_corr = STEER_MIN[VEL_W-1:0];
      end else begin
         steer_corr = steer_sum[VEL_W-1:0];
      end
   end

   // ---------------------------------------------------------- stage chain
   always_comb begin
      lin_v         = '0;
      ang_v         = '0;
      steer_v       = '0;
      vest_v        = 1'b0;
      iact_v        = 1'b0;
      iest_v        = 1'b0;
      flags_in      = flags_ff;
      last_trees_in = last_trees_ff;
      if (apply_fire) begin
         unique case (func_ff)
            FUNC_VEHICLE: begin
               lin_v         = lin_ff;
               ang_v         = ang_ff;
               steer_v       = steer_ff;
               vest_v        = estop_ff;
               last_trees_in = trees_ff;
               if (enable_ff[EN_COLLISION]) begin
                  if (dist_ff < brake_ff) begin
                     lin_v               = '0;
                     vest_v              = 1'b1;
                     flags_in[FL_BRAKING] = 1'b1;
                  end else if (dist_ff < warn_ff) begin
                     lin_v               = lin_scaled;
                     flags_in[FL_WARNING] = 1'b1;
                  end else begin
                     flags_in[FL_WARNING] = 1'b0;
                     flags_in[FL_BRAKING] = 1'b0;
                  end
               end
               if (enable_ff[EN_LANE] && lane_ff) begin
                  if (off_mag > LANE_THRESH) begin
                     steer_v          = steer_corr;
                     flags_in[FL_LANE] = 1'b1;
                  end else begin
                     flags_in[FL_LANE] = 1'b0;
                  end
               end
               if (enable_ff[EN_CRUISE]) begin
                  if (dist_ff < FOLLOW_DIST && dist_ff > warn_ff) begin
                     if (lin_v > $signed({1'b0, dist_ff[DIST_W-1:2]})) begin
                        lin_v              = $signed({1'b0, dist_ff[DIST_W-1:2]});
                        flags_in[FL_CRUISE] = 1'b1;
                     end
                  end else begin
                     flags_in[FL_CRUISE] = 1'b0;
                  end
               end
               if (enable_ff[EN_TREE]) begin
                  if (trees_ff) begin
                     if (lin_v > TREE_SPEED) begin
                        lin_v            = TREE_SPEED;
                        flags_in[FL_TREE] = 1'b1;
                     end
                  end else begin
                     flags_in[FL_TREE] = 1'b0;
                  end
               end
               if (enable_ff[EN_GPS]) begin
                  if (gps_acc_ff > gps_thresh_ff) begin
                     lin_v           = '0;
                     ang_v           = '0;
                     flags_in[FL_GPS] = 1'b1;
                  end else begin
                     flags_in[FL_GPS] = 1'b0;
                  end
               end
               if (enable_ff[EN_LIMIT]) begin
                  if (lin_v > $signed({1'b0, max_speed_ff})) begin
                     lin_v             = $signed({1'b0, max_speed_ff});
                     flags_in[FL_LIMIT] = 1'b1;
                  end else begin
                     flags_in[FL_LIMIT] = 1'b0;
                  end
               end
            end
            FUNC_IMPLEMENT: begin
               iact_v = activate_ff && !flags_ff[FL_BRAKING]
                        && !(enable_ff[EN_TREE] && last_trees_ff)
                        && !(enable_ff[EN_GPS] && flags_ff[FL_GPS]);
               iest_v = estop_ff || flags_ff[FL_BRAKING];
            end
            FUNC_ESTOP: begin
               flags_in[FL_BRAKING] = 1'b1;
               vest_v               = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // safety level from the flags after this word, floored at zero
   always_comb begin
      penalty = (flags_in[FL_WARNING] ? PEN_WARN  : '0)
              + (flags_in[FL_BRAKING] ? PEN_BRAKE : '0)
              + (flags_in[FL_GPS]     ? PEN_GPS   : '0)
              + (flags_in[FL_TREE]    ? PEN_TREE  : '0);
      level_v = (penalty >= LEVEL_FULL) ? '0 : (LEVEL_FULL - penalty);
   end

   // ---------------------------------------------------------- result word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (apply_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (apply_fire) begin
         rsp_lin_ff   <= lin_v;
         rsp_ang_ff   <= ang_v;
         rsp_steer_ff <= steer_v;
         rsp_vest_ff  <= vest_v;
         rsp_iact_ff  <= iact_v;
         rsp_iest_ff  <= iest_v;
         rsp_flags_ff <= flags_in;
         rsp_level_ff <= level_v;
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_linear_velocity_out    = rsp_lin_ff;
   assign rsp_angular_velocity_out   = rsp_ang_ff;
   assign rsp_steering_out           = rsp_steer_ff;
   assign rsp_vehicle_estop_out      = rsp_vest_ff;
   assign rsp_implement_activate_out = rsp_iact_ff;
   assign rsp_implement_estop_out    = rsp_iest_ff;
   assign rsp_flag_bits              = rsp_flags_ff;
   assign rsp_safety_score           = rsp_level_ff;

endmodule

// ----- test/vehicle_command_safety_governor_test.sv -----
// ----------------------------------------------------------------------------
// vehicle_command_safety_governor_test - self-checking bench of the governor
// A short drill of commands at the default settings, most hand-checked,
// then random phases under extreme, default and random register settings.
// A behavioural bench governor predicts each result word, which is compared
// field by field, in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vehicle_command_safety_governor_test;
   import vcsg_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 9;
   localparam int PHASE_WORDS    = 95;
   localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE   = 3'd7;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [VEL_W-1:0]  lin;
      logic [VEL_W-1:0]  ang;
      logic [VEL_W-1:0]  steer;
      logic              estop;
      logic              activate;
      logic [DIST_W-1:0] obst;
      logic [VEL_W-1:0]  off;
      logic [GPS_W-1:0]  gps;
      logic              trees;
      logic              lane;
   } command_type;

   typedef struct packed {
      logic [VEL_W-1:0]   lin;
      logic [VEL_W-1:0]   ang;
      logic [VEL_W-1:0]   steer;
      logic               vest;
      logic               iact;
      logic               iest;
      logic [FLAG_W-1:0]  flags;
      logic [LEVEL_W-1:0] level;
   } verdict_type;

   typedef struct packed {
      command_type c;
      logic        typed;
      verdict_type v;
   } drill_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic [FUNC_W-1:0]     req_func    = '0;
   logic signed [VEL_W-1:0] req_linear_velocity_in  = '0;
   logic signed [VEL_W-1:0] req_angular_velocity_in = '0;
   logic signed [VEL_W-1:0] req_steering_in         = '0;
   logic                  req_estop_in    = 1'b0;
   logic                  req_activate_in = 1'b0;
   logic [DIST_W-1:0]     req_obstacle_distance = '0;
   logic signed [VEL_W-1:0] req_lane_offset     = '0;
   logic [GPS_W-1:0]      req_gps_accuracy = '0;
   logic                  req_trees_seen   = 1'b0;
   logic                  req_lane_seen    = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [VEL_W-1:0] rsp_linear_velocity_out;
   logic signed [VEL_W-1:0] rsp_angular_velocity_out;
   logic signed [VEL_W-1:0] rsp_steering_out;
   logic                  rsp_vehicle_estop_out;
   logic                  rsp_implement_activate_out;
   logic                  rsp_implement_estop_out;
   logic [FLAG_W-1:0]     rsp_flag_bits;
   logic [LEVEL_W-1:0]    rsp_safety_score;

   // predicted governor state and registers
   logic [FLAG_W-1:0]   status;
   logic                trees_latched;
   logic [MASK_W-1:0]   en_mask;
   logic [DIST_W-1:0]   warn_dist;
   logic [DIST_W-1:0]   brake_dist;
   logic [MAXSPD_W-1:0] speed_cap;
   logic [GPS_W-1:0]    gps_limit;

   verdict_type   verdicts[$];
   drill_row_type drill[$];
   verdict_type   blank = '0;
   verdict_type   head;
   int            faults = 0;
   int            stall_left = 0;
   int            quiet = 0;
   bit            calm = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   vehicle_command_safety_governor u_dut (
      .clock                      (clock),
      .reset                      (reset),
      .csr_wr_en                  (csr_wr_en),
      .csr_index                  (csr_index),
      .csr_wr_data                (csr_wr_data),
      .req_valid                  (req_valid),
      .req_stall                  (req_stall),
      .req_func                   (req_func),
      .req_linear_velocity_in     (req_linear_velocity_in),
      .req_angular_velocity_in    (req_angular_velocity_in),
      .req_steering_in            (req_steering_in),
      .req_estop_in               (req_estop_in),
      .req_activate_in            (req_activate_in),
      .req_obstacle_distance      (req_obstacle_distance),
      .req_lane_offset            (req_lane_offset),
      .req_gps_accuracy           (req_gps_accuracy),
      .req_trees_seen             (req_trees_seen),
      .req_lane_seen              (req_lane_seen),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_linear_velocity_out    (rsp_linear_velocity_out),
      .rsp_angular_velocity_out   (rsp_angular_velocity_out),
      .rsp_steering_out           (rsp_steering_out),
      .rsp_vehicle_estop_out      (rsp_vehicle_estop_out),
      .rsp_implement_activate_out (rsp_implement_activate_out),
      .rsp_implement_estop_out    (rsp_implement_estop_out),
      .rsp_flag_bits              (rsp_flag_bits),
      .rsp_safety_score           (rsp_safety_score)
   );

   function automatic void reset_governor();
      status        = '0;
      trees_latched = 1'b0;
      en_mask       = RST_ENABLE_MASK;
      warn_dist     = RST_WARNING;
      brake_dist    = RST_BRAKE;
      speed_cap     = RST_MAX_SPEED;
      gps_limit     = RST_GPS_THRESH;
   endfunction

   function automatic void set_register(input logic [CSR_IDX_W-1:0] idx,
                                        input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_ENABLE_MASK:      en_mask    = data[MASK_W-1:0];
         CSR_WARNING_DISTANCE: warn_dist  = data[DIST_W-1:0];
         CSR_BRAKE_DISTANCE:   brake_dist = data[DIST_W-1:0];
         CSR_MAX_SPEED:        speed_cap  = data[MAXSPD_W-1:0];
         CSR_GPS_THRESHOLD:    gps_limit  = data[GPS_W-1:0];
         default: ;
      endcase
   endfunction

   // run one command through the filter stages and update the sticky flags
   function automatic verdict_type govern(input command_type c);
      verdict_type v;
      int lin, ang, steer, off, range_mm, brk, wrn, mag, corr, level;
      v        = '0;
      lin      = 0;
      ang      = 0;
      steer    = 0;
      range_mm = int'(c.obst);
      brk      = int'(brake_dist);
      wrn      = int'(warn_dist);
      case (c.func)
         FUNC_VEHICLE: begin
            lin    = $signed(c.lin);
            ang    = $signed(c.ang);
            steer  = $signed(c.steer);
            off    = $signed(c.off);
            v.vest = c.estop;
            trees_latched = c.trees;
            if (en_mask[EN_COLLISION]) begin
               if (range_mm < brk) begin
                  lin = 0;
                  v.vest = 1'b1;
                  status[FL_BRAKING] = 1'b1;
               end else if (range_mm < wrn) begin
                  // scale across the warning band, truncating toward zero
                  lin = int'(longint'(lin) * (range_mm - brk) / (wrn - brk));
                  status[FL_WARNING] = 1'b1;
               end else begin
                  status[FL_WARNING] = 1'b0;
                  status[FL_BRAKING] = 1'b0;
               end
            end
            if (en_mask[EN_LANE] && c.lane) begin
               mag = (off < 0) ? -off : off;
               if (mag > int'(LANE_THRESH)) begin
                  corr = -off / 10;
                  if (corr > int'(LANE_MAX_CORR)) corr = int'(LANE_MAX_CORR);
                  if (corr < -int'(LANE_MAX_CORR)) corr = -int'(LANE_MAX_CORR);
                  steer = steer + corr;
                  if (steer > int'(STEER_MAX)) steer = int'(STEER_MAX);
                  if (steer < int'(STEER_MIN)) steer = int'(STEER_MIN);
                  status[FL_LANE] = 1'b1;
               end else begin
                  status[FL_LANE] = 1'b0;
               end
            end
            if (en_mask[EN_CRUISE]) begin
               if (range_mm < int'(FOLLOW_DIST) && range_mm > wrn) begin
                  if (lin > range_mm / 4) begin
                     lin = range_mm / 4;
                     status[FL_CRUISE] = 1'b1;
                  end
               end else begin
                  status[FL_CRUISE] = 1'b0;
               end
            end
            if (en_mask[EN_TREE]) begin
               if (c.trees) begin
                  if (lin > int'(TREE_SPEED)) begin
                     lin = int'(TREE_SPEED);
                     status[FL_TREE] = 1'b1;
                  end
               end else begin
                  status[FL_TREE] = 1'b0;
               end
            end
            if (en_mask[EN_GPS]) begin
               if (c.gps > gps_limit) begin
                  lin = 0;
                  ang = 0;
                  status[FL_GPS] = 1'b1;
               end else begin
                  status[FL_GPS] = 1'b0;
               end
            end
            if (en_mask[EN_LIMIT]) begin
               if (lin > int'(speed_cap)) begin
                  lin = int'(speed_cap);
                  status[FL_LIMIT] = 1'b1;
               end else begin
                  status[FL_LIMIT] = 1'b0;
               end
            end
         end
         FUNC_IMPLEMENT: begin
            v.iact = c.activate;
            v.iest = c.estop;
            if (status[FL_BRAKING]) begin
               v.iact = 1'b0;
               v.iest = 1'b1;
            end
            if (en_mask[EN_TREE] && trees_latched) v.iact = 1'b0;
            if (en_mask[EN_GPS] && status[FL_GPS]) v.iact = 1'b0;
         end
         FUNC_ESTOP: begin
            status[FL_BRAKING] = 1'b1;
            v.vest = 1'b1;
         end
         default: ;
      endcase
      level = int'(LEVEL_FULL);
      if (status[FL_WARNING]) level -= int'(PEN_WARN);
      if (status[FL_BRAKING]) level -= int'(PEN_BRAKE);
      if (status[FL_GPS])     level -= int'(PEN_GPS);
      if (status[FL_TREE])    level -= int'(PEN_TREE);
      if (level < 0) level = 0;
      v.lin   = 16'(lin);
      v.ang   = 16'(ang);
      v.steer = 16'(steer);
      v.flags = status;
      v.level = 7'(level);
      return v;
   endfunction

   function automatic command_type cmd(input logic [FUNC_W-1:0] f, input int lin, ang,
                                       steer, input bit estop, act, input int range_mm, off,
                                       gps, input bit trees, lane);
      command_type c;
      c.func     = f;
      c.lin      = 16'(lin);
      c.ang      = 16'(ang);
      c.steer    = 16'(steer);
      c.estop    = estop;
      c.activate = act;
      c.obst     = 17'(range_mm);
      c.off      = 16'(off);
      c.gps      = 16'(gps);
      c.trees    = trees;
      c.lane     = lane;
      return c;
   endfunction

   function automatic verdict_type want(input int lin, ang, steer, input bit vest, iact,
                                        iest, input int flags, level);
      verdict_type v;
      v.lin   = 16'(lin);
      v.ang   = 16'(ang);
      v.steer = 16'(steer);
      v.vest  = vest;
      v.iact  = iact;
      v.iest  = iest;
      v.flags = 7'(flags);
      v.level = 7'(level);
      return v;
   endfunction

   task automatic add_row(input command_type c, input bit typed, input verdict_type v);
      drill_row_type row;
      row.c     = c;
      row.typed = typed;
      row.v     = v;
      drill.insert(drill.size(), row);
   endtask

   function automatic int pause_length();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // random command aimed at the stage boundaries of the current settings
   function automatic command_type draw_command();
      command_type c;
      int r;
      r = $urandom_range(0, 99);
      if (r < 72)      c.func = FUNC_VEHICLE;
      else if (r < 87) c.func = FUNC_IMPLEMENT;
      else if (r < 97) c.func = FUNC_ESTOP;
      else             c.func = FUNC_UNUSED;
      case ($urandom_range(0, 4))
         0:       c.lin = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
         1, 2:    c.lin = 16'($urandom);
         default: c.lin = 16'(int'($urandom_range(0, 7000)) - 1000);
      endcase
      c.ang      = 16'($urandom);
      c.steer    = ($urandom_range(0, 3) == 0) ? 16'(32767 - $urandom_range(0, 200) +
                   ($urandom_range(0, 1) != 0 ? 0 : 32768)) : 16'($urandom);
      c.estop    = 1'($urandom);
      c.activate = 1'($urandom);
      c.trees    = 1'($urandom);
      c.lane     = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
         0:       c.obst = 17'($urandom);
         1:       c.obst = 17'(brake_dist + $urandom_range(0, 6) - 3);
         2:       c.obst = 17'(warn_dist + $urandom_range(0, 6) - 3);
         3:       c.obst = 17'(FOLLOW_DIST + $urandom_range(0, 6) - 3);
         default: c.obst = 17'($urandom_range(0, 25000));
      endcase
      case ($urandom_range(0, 4))
         0, 1:    c.off = 16'($urandom);
         2:       c.off = 16'(($urandom_range(0, 1) != 0 ? 500 : -500) +
                          int'($urandom_range(0, 6)) - 3);
         default: c.off = 16'(int'($urandom_range(0, 2000)) - 1000);
      endcase
      case ($urandom_range(0, 4))
         0, 1:    c.gps = 16'(gps_limit + $urandom_range(0, 4) - 2);
         2:       c.gps = 16'($urandom);
         default: c.gps = 16'($urandom_range(0, int'(gps_limit)));
      endcase
      return c;
   endfunction

   // offer one command word, then predict once it is taken
   task automatic issue(input command_type c, input bit typed, input verdict_type v);
      int gap;
      verdict_type predicted;
      gap = pause_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_func                <= c.func;
      req_linear_velocity_in  <= c.lin;
      req_angular_velocity_in <= c.ang;
      req_steering_in         <= c.steer;
      req_estop_in            <= c.estop;
      req_activate_in         <= c.activate;
      req_obstacle_distance   <= c.obst;
      req_lane_offset         <= c.off;
      req_gps_accuracy        <= c.gps;
      req_trees_seen          <= c.trees;
      req_lane_seen           <= c.lane;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = govern(c);
      verdicts.insert(verdicts.size(), typed ? v : predicted);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      set_register(idx, data);
   endtask

   task automatic configure(input int phase);
      logic [CSR_DATA_W-1:0] mask_d, warn_d, brake_d, speed_d, gps_d;
      int w;
      w       = $urandom_range(4000, 25000);
      mask_d  = {11'($urandom), 6'($urandom)};
      warn_d  = 17'(w);
      brake_d = 17'($urandom_range(0, w));
      speed_d = {2'($urandom), 15'($urandom_range(0, 8000))};
      gps_d   = {1'($urandom), 16'($urandom_range(0, 3000))};
      case (phase)
         1: mask_d = {11'($urandom), 6'd0};
         2: begin
            mask_d  = 17'd63;
            warn_d  = '0;
            brake_d = '0;
            speed_d = '0;
            gps_d   = '0;
         end
         3: begin
            mask_d  = 17'd63;
            warn_d  = 17'h1FFFF;
            brake_d = 17'h1FFFF;
            speed_d = 17'h7FFF;
            gps_d   = 17'hFFFF;
         end
         // brake band wider than the warning band
         4: begin
            warn_d  = 17'd2000;
            brake_d = 17'd8000;
         end
         5: begin
            mask_d  = 17'(RST_ENABLE_MASK);
            warn_d  = RST_WARNING;
            brake_d = RST_BRAKE;
            speed_d = 17'(RST_MAX_SPEED);
            gps_d   = 17'(RST_GPS_THRESH);
         end
         default: ;
      endcase
      write_register(CSR_ENABLE_MASK, mask_d);
      write_register(CSR_WARNING_DISTANCE, warn_d);
      write_register(CSR_BRAKE_DISTANCE, brake_d);
      write_register(CSR_MAX_SPEED, speed_d);
      write_register(CSR_GPS_THRESHOLD, gps_d);
      if (phase == 1) write_register(CSR_SPARE, 17'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   task automatic compare_field(input string name, input logic signed [31:0] exp_v,
                                input logic signed [31:0] act_v);
      if (exp_v !== act_v) begin
         faults++;
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   // result side: check each taken word and draw the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdicts.size() == 0) begin
               faults++;
               $display("%0t: result word with no command outstanding", $time);
            end else begin
               head = verdicts.pop_front();
               compare_field("linear_velocity_out", $signed(head.lin),
                             rsp_linear_velocity_out);
               compare_field("angular_velocity_out", $signed(head.ang),
                             rsp_angular_velocity_out);
               compare_field("steering_out", $signed(head.steer), rsp_steering_out);
               compare_field("vehicle_estop_out", head.vest, rsp_vehicle_estop_out);
               compare_field("implement_activate_out", head.iact,
                             rsp_implement_activate_out);
               compare_field("implement_estop_out", head.iest, rsp_implement_estop_out);
               compare_field("flag_bits", head.flags, rsp_flag_bits);
               compare_field("safety_score", head.level, rsp_safety_score);
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = pause_length();
         end
      end
   end

   // abort when neither channel nor the register port moves for too long
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet == WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      reset_governor();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // mostly hand-checked words at the default settings; flags carry over row to row
      add_row(cmd(FUNC_VEHICLE, 1000, 50, 0, 0, 0, 30000, 0, 0, 0, 1), 1,
              want(1000, 50, 0, 0, 0, 0, 0, 100));
      add_row(cmd(FUNC_VEHICLE, 3000, 7, 12, 0, 0, 100, 0, 0, 0, 0), 1,
              want(0, 7, 12, 1, 0, 0, 2, 50));
      add_row(cmd(FUNC_IMPLEMENT, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0), 1,
              want(0, 0, 0, 0, 0, 1, 2, 50));
      add_row(cmd(FUNC_VEHICLE, 32767, -32768, -32768, 0, 0, 0, 0, 0, 0, 0), 1,
              want(0, -32768, -32768, 1, 0, 0, 2, 50));
      // most negative velocity passes; offset and accuracy sit on their limits
      add_row(cmd(FUNC_VEHICLE, -32768, 32767, 32767, 1, 0, 131071, 500, 100, 1, 1), 1,
              want(-32768, 32767, 32767, 1, 0, 0, 0, 100));
      add_row(cmd(FUNC_IMPLEMENT, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0), 1,
              want(0, 0, 0, 0, 0, 0, 0, 100));
      add_row(cmd(FUNC_VEHICLE, 4000, 0, 0, 0, 0, 6500, 0, 0, 0, 0), 1,
              want(2000, 0, 0, 0, 0, 0, 1, 70));
      add_row(cmd(FUNC_VEHICLE, -7001, 0, 0, 0, 0, 4000, 0, 0, 0, 0), 1,
              want(-1000, 0, 0, 0, 0, 0, 1, 70));
      add_row(cmd(FUNC_VEHICLE, 0, 0, 100, 0, 0, 50000, 501, 0, 0, 1), 1,
              want(0, 0, 50, 0, 0, 0, 4, 100));
      add_row(cmd(FUNC_VEHICLE, 0, 0, 32767, 0, 0, 50000, -32768, 0, 0, 1), 1,
              want(0, 0, 32767, 0, 0, 0, 4, 100));
      add_row(cmd(FUNC_VEHICLE, 0, 0, -32768, 0, 0, 50000, 32767, 0, 0, 1), 1,
              want(0, 0, -32767, 0, 0, 0, 4, 100));
      add_row(cmd(FUNC_VEHICLE, 0, 0, 0, 0, 0, 50000, -999, 0, 0, 1), 1,
              want(0, 0, 99, 0, 0, 0, 4, 100));
      add_row(cmd(FUNC_VEHICLE, 4000, 0, 0, 0, 0, 12000, 0, 0, 0, 0), 1,
              want(3000, 0, 0, 0, 0, 0, 12, 100));
      add_row(cmd(FUNC_VEHICLE, 1000, 0, 0, 0, 0, 12000, 0, 0, 0, 0), 1,
              want(1000, 0, 0, 0, 0, 0, 12, 100));
      add_row(cmd(FUNC_VEHICLE, 4500, 0, 0, 0, 0, 50000, 0, 0, 1, 0), 1,
              want(2000, 0, 0, 0, 0, 0, 20, 90));
      add_row(cmd(FUNC_VEHICLE, 1000, 300, 0, 0, 0, 50000, 0, 101, 0, 0), 1,
              want(0, 0, 0, 0, 0, 0, 36, 80));
      add_row(cmd(FUNC_IMPLEMENT, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0), 1,
              want(0, 0, 0, 0, 0, 1, 36, 80));
      add_row(cmd(FUNC_VEHICLE, 32767, 0, 0, 0, 0, 50000, 0, 0, 0, 0), 1,
              want(5000, 0, 0, 0, 0, 0, 68, 100));
      add_row(cmd(FUNC_ESTOP, 1234, 55, 66, 0, 1, 0, 0, 0, 0, 0), 1,
              want(0, 0, 0, 1, 0, 0, 70, 50));
      add_row(cmd(FUNC_UNUSED, 1234, 55, 66, 1, 1, 0, 0, 999, 1, 1), 1,
              want(0, 0, 0, 0, 0, 0, 70, 50));
      // every penalty at once floors the level
      add_row(cmd(FUNC_VEHICLE, 32767, 55, 0, 0, 0, 5000, 0, 500, 1, 0), 1,
              want(0, 0, 0, 0, 0, 0, 55, 0));
      add_row(cmd(FUNC_IMPLEMENT, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0), 1,
              want(0, 0, 0, 0, 0, 1, 55, 0));
      add_row(cmd(FUNC_VEHICLE, 0, 0, 0, 0, 0, 131071, 0, 0, 0, 1), 1,
              want(0, 0, 0, 0, 0, 0, 0, 100));
      add_row(cmd(FUNC_VEHICLE, 12345, -77, 1000, 0, 0, 9999, -12345, 100, 1, 1), 0, blank);
      add_row(cmd(FUNC_VEHICLE, -32768, 0, 0, 0, 0, 3000, 0, 0, 0, 0), 0, blank);

      foreach (drill[i]) issue(drill[i].c, drill[i].typed, drill[i].v);

      for (int phase = 1; phase <= PHASES; phase++) begin
         drain();
         configure(phase);
         calm = (phase == 5);
         repeat (PHASE_WORDS) issue(draw_command(), 1'b0, blank);
      end
      calm = 1'b0;
      drain();
      repeat (30) @(posedge clock);

      if (verdicts.size() != 0) begin
         faults++;
         $display("%0t: %0d result words never arrived", $time, verdicts.size());
      end
      if (faults == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
